>>> rtl/vcsf_pkg.sv
// ----------------------------------------------------------------------------
// vcsf_pkg
// Shared types and constants for the voxel column scan fill block.
// ----------------------------------------------------------------------------
package vcsf_pkg;

  localparam int unsigned ColW       = 64;  // width of a column item
  localparam int unsigned CfgW       = 7;   // width of the column length register
  localparam int unsigned MaxColDef  = 64;  // default longest column
  localparam logic [CfgW-1:0] LenRst = 7'd64;

  // Per-voxel scan states
  localparam logic [1:0] ScanOutside  = 2'd0;
  localparam logic [1:0] ScanBoundOut = 2'd1;
  localparam logic [1:0] ScanInside   = 2'd2;
  localparam logic [1:0] ScanBoundIn  = 2'd3;

  // Sequencer to datapath
  typedef struct packed {
    logic load;    // capture a new column
    logic step;    // examine one voxel
    logic fill;    // set the current voxel in the result
    logic finish;  // result is complete, move it out
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic cur_bit;    // surface bit at the current voxel
    logic rest_zero;  // no surface bit at or above the current voxel
  } stat_t;

endpackage

>>> rtl/vcsf_scan.sv
// ----------------------------------------------------------------------------
// vcsf_scan
// Column datapath: shift register that presents one voxel per cycle with its
// look-ahead test, and the result register that collects the filled voxels.
// ----------------------------------------------------------------------------
module vcsf_scan #(
  parameter int unsigned MAX_COLUMN = vcsf_pkg::MaxColDef,
  parameter int unsigned IdxW       = (MAX_COLUMN > 1) ? $clog2(MAX_COLUMN) : 1,
  parameter int unsigned CntW       = $clog2(MAX_COLUMN + 1)
) (
  input  logic                  clk_i,
  input  vcsf_pkg::ctrl_t       ctrl_i,
  input  logic [CntW-1:0]       len_i,
  input  logic [IdxW-1:0]       idx_i,
  input  logic [MAX_COLUMN-1:0] bits_i,
  output vcsf_pkg::stat_t       stat_o,
  output logic [MAX_COLUMN-1:0] result_o
);
  import vcsf_pkg::*;

  logic [MAX_COLUMN-1:0] mask;
  logic [MAX_COLUMN-1:0] sh_d, sh_q;
  logic [MAX_COLUMN-1:0] res_d, res_q;

  always_comb begin
    for (int i = 0; i < MAX_COLUMN; i++) begin
      mask[i] = (CntW'(i) < len_i);
    end
  end

  always_comb begin
    sh_d  = sh_q;
    res_d = res_q;
    if (ctrl_i.load) begin
      sh_d  = bits_i & mask;
      res_d = bits_i & mask;
    end else if (ctrl_i.step) begin
      // advance to the next voxel; the look-ahead always sees what remains
      sh_d = sh_q >> 1;
      if (ctrl_i.fill) begin
        res_d[idx_i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    res_q <= res_d;
  end

  assign stat_o.cur_bit   = sh_q[0];
  assign stat_o.rest_zero = (sh_q == '0);
  assign result_o         = res_q;

endmodule

>>> rtl/vcsf_ctrl.sv
// ----------------------------------------------------------------------------
// vcsf_ctrl
// Sequencer: walks the voxel index over the column and runs the four-state
// boundary scan that decides which voxels to fill.
// ----------------------------------------------------------------------------
module vcsf_ctrl #(
  parameter int unsigned MAX_COLUMN = vcsf_pkg::MaxColDef,
  parameter int unsigned IdxW       = (MAX_COLUMN > 1) ? $clog2(MAX_COLUMN) : 1,
  parameter int unsigned CntW       = $clog2(MAX_COLUMN + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [CntW-1:0] len_i,
  input  logic            out_free_i,
  input  vcsf_pkg::stat_t stat_i,
  output logic            busy_o,
  output vcsf_pkg::ctrl_t ctrl_o,
  output logic [IdxW-1:0] idx_o
);
  import vcsf_pkg::*;

  localparam logic SeqIdle = 1'b0;
  localparam logic SeqScan = 1'b1;

  logic            seq_d, seq_q;
  logic [1:0]      scan_d, scan_q;
  logic [CntW-1:0] z_d, z_q;
  logic [CntW-1:0] len_d, len_q;
  logic            at_end;

  assign at_end = (z_q == len_q);

  always_comb begin
    seq_d       = seq_q;
    scan_d      = scan_q;
    z_d         = z_q;
    len_d       = len_q;
    ctrl_o      = '0;
    unique case (seq_q)
      SeqIdle: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          seq_d       = SeqScan;
          scan_d      = ScanOutside;
          z_d         = '0;
          len_d       = len_i;
        end
      end
      SeqScan: begin
        if (!at_end) begin
          ctrl_o.step = 1'b1;
          z_d         = z_q + CntW'(1);
          unique case (scan_q)
            ScanOutside: begin
              if (stat_i.cur_bit) scan_d = ScanBoundOut;
            end
            ScanBoundOut: begin
              if (!stat_i.cur_bit) begin
                if (stat_i.rest_zero) begin
                  scan_d = ScanOutside;
                end else begin
                  scan_d      = ScanInside;
                  ctrl_o.fill = 1'b1;
                end
              end
            end
            ScanInside: begin
              if (stat_i.cur_bit) scan_d = ScanBoundIn;
              else ctrl_o.fill = 1'b1;
            end
            default: begin
              if (!stat_i.cur_bit) scan_d = ScanOutside;
            end
          endcase
        end else if (out_free_i) begin
          // hold the result until the output register can take it
          ctrl_o.finish = 1'b1;
          seq_d         = SeqIdle;
        end
      end
      default: seq_d = SeqIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= SeqIdle;
      scan_q <= ScanOutside;
      z_q    <= '0;
      len_q  <= '0;
    end else begin
      seq_q  <= seq_d;
      scan_q <= scan_d;
      z_q    <= z_d;
      len_q  <= len_d;
    end
  end

  assign busy_o = (seq_q == SeqScan);
  assign idx_o  = z_q[IdxW-1:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_o |-> (z_q <= len_q))
    else $error("voxel index ran past the column length");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl_o.load |=> busy_o && z_q == '0)
    else $error("scan did not start at voxel zero after load");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl_o.finish |-> out_free_i && at_end)
    else $error("result moved out before scan end or into a full output");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl_o.fill |-> !stat_i.cur_bit)
    else $error("fill issued on a surface voxel");

endmodule

>>> rtl/voxel_column_scan_fill_top.sv
// ----------------------------------------------------------------------------
// voxel_column_scan_fill_top
// Fills the interior of one column of surface voxels along z.
// ----------------------------------------------------------------------------
// One column item is scanned one voxel per cycle through the shared bit
// examiner after it is accepted, then moved to the output register in a
// write-out step. column_length is capped at MAX_COLUMN, and a zero length
// goes straight to write-out. in_ready_o comes back the cycle after write-out,
// so a new item is accepted only after the previous one is written out. If the
// previous result still waits on out_ready_i when a scan ends, write-out and
// in_ready_o hold until that result is taken. A result waiting in the output
// register overlaps the next scan. Bits at or above the column length are
// ignored and return as zero. Write column_length only while idle.
module voxel_column_scan_fill_top #(
  parameter int unsigned MAX_COLUMN = vcsf_pkg::MaxColDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [vcsf_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [vcsf_pkg::ColW-1:0] column_bits_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [vcsf_pkg::ColW-1:0] filled_bits_o
);
  import vcsf_pkg::*;

  localparam int unsigned IdxW = (MAX_COLUMN > 1) ? $clog2(MAX_COLUMN) : 1;
  localparam int unsigned CntW = $clog2(MAX_COLUMN + 1);

  logic [CfgW-1:0]       len_cfg_q;
  logic [CntW-1:0]       len_sat;
  logic                  busy;
  logic                  start;
  logic                  out_free;
  logic [IdxW-1:0]       idx;
  ctrl_t                 ctrl;
  stat_t                 stat;
  logic [MAX_COLUMN-1:0] result;
  logic                  out_valid_q;
  logic [ColW-1:0]       filled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= LenRst;
    end else if (cfg_we_i) begin
      len_cfg_q <= cfg_wdata_i;
    end
  end

  // saturate the length to the longest column handled
  assign len_sat = (len_cfg_q > CfgW'(MAX_COLUMN)) ? CntW'(MAX_COLUMN)
                                                  : len_cfg_q[CntW-1:0];

  assign in_ready_o = !busy;
  assign start      = in_valid_i && !busy;
  assign out_free   = !out_valid_q || out_ready_i;

  vcsf_ctrl #(
    .MAX_COLUMN(MAX_COLUMN),
    .IdxW      (IdxW),
    .CntW      (CntW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .len_i     (len_sat),
    .out_free_i(out_free),
    .stat_i    (stat),
    .busy_o    (busy),
    .ctrl_o    (ctrl),
    .idx_o     (idx)
  );

  vcsf_scan #(
    .MAX_COLUMN(MAX_COLUMN),
    .IdxW      (IdxW),
    .CntW      (CntW)
  ) u_scan (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .len_i   (len_sat),
    .idx_i   (idx),
    .bits_i  (column_bits_i[MAX_COLUMN-1:0]),
    .stat_o  (stat),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      filled_q <= ColW'(result);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign filled_bits_o = filled_q;

endmodule

>>> test/voxel_column_scan_fill_top_tb.sv
// ----------------------------------------------------------------------------
// voxel_column_scan_fill_top_tb
// Feeds surface-voxel columns through the fill block. The directed rows cover
// the extremes, the length limits and bits beyond the column. The random
// phases then sweep column_length, mostly with shell-like columns. Every
// result is compared in order with its expected value, taken from a typed row
// or from a local scan-fill predictor. The sender works in bursts and the
// receiver stalls on its own pattern.
module voxel_column_scan_fill_top_tb;
  import vcsf_pkg::*;

  localparam int unsigned MaxCol    = MaxColDef;
  localparam int unsigned CycleCap  = 1_000_000;
  localparam int unsigned HoldLen   = 400;
  localparam int unsigned NumDir    = 22;
  localparam int unsigned NumPhases = 12;

  typedef enum logic [1:0] {RxOpen, RxCoin, RxSparse, RxComb} rx_mode_e;

  typedef struct {
    logic [CfgW-1:0] len;
    logic [ColW-1:0] bits;
    bit              typed;
    logic [ColW-1:0] want;
  } col_row_t;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            cfg_we_i      = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i   = '0;
  logic            in_valid_i    = 1'b0;
  logic            in_ready_o;
  logic [ColW-1:0] column_bits_i = '0;
  logic            out_valid_o;
  logic            out_ready_i   = 1'b0;
  logic [ColW-1:0] filled_bits_o;

  logic [ColW-1:0] filled_q[$];
  logic [ColW-1:0] want_bits;
  logic [CfgW-1:0] cur_len = LenRst;
  int unsigned     cycle_cnt = 0;
  int unsigned     hold_left = 0;
  int unsigned     errors = 0;
  int unsigned     sent = 0;
  int unsigned     checked = 0;
  int unsigned     len_writes = 0;
  logic            long_hold_go = 1'b0;
  logic            long_hold_done = 1'b0;

  // Rows with a typed result can be read straight off the scan rules.
  col_row_t dir_rows [NumDir] = '{
    '{7'd64,  64'h0,                   1'b1, 64'h0},
    '{7'd64,  '1,                      1'b1, '1},
    '{7'd64,  64'h8000_0000_0000_0001, 1'b1, '1},
    '{7'd64,  64'h1,                   1'b1, 64'h1},
    '{7'd64,  64'h8000_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0000},
    '{7'd64,  64'h5,                   1'b0, 64'h0},
    '{7'd64,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
    '{7'd64,  64'h0000_0000_0011_0011, 1'b0, 64'h0},
    '{7'd64,  64'h0000_0000_0000_C003, 1'b0, 64'h0},
    '{7'd64,  64'h0000_0001_0000_0006, 1'b0, 64'h0},
    '{7'd0,   '1,                      1'b1, 64'h0},
    '{7'd0,   64'h1234_5678_9ABC_DEF0, 1'b1, 64'h0},
    '{7'd1,   '1,                      1'b1, 64'h1},
    '{7'd1,   64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 64'h0},
    '{7'd2,   64'h3,                   1'b1, 64'h3},
    '{7'd32,  '1,                      1'b1, 64'h0000_0000_FFFF_FFFF},
    '{7'd32,  64'h0000_0100_0000_0001, 1'b1, 64'h1},
    '{7'd63,  64'h8000_0000_0000_0001, 1'b1, 64'h1},
    '{7'd127, 64'h8000_0000_0000_0001, 1'b1, '1},
    '{7'd65,  '1,                      1'b1, '1},
    '{7'd127, 64'h0F0F_00F0_0F00_F00F, 1'b0, 64'h0},
    '{7'd64,  64'h0000_0000_0000_0009, 1'b0, 64'h0}
  };

  voxel_column_scan_fill_top #(
    .MAX_COLUMN(MaxCol)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .column_bits_i(column_bits_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .filled_bits_o(filled_bits_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleCap) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Scan one column bottom-up and fill between outer and inner boundaries.
  function automatic logic [ColW-1:0] fill_column(logic [ColW-1:0] surf,
                                                  logic [CfgW-1:0] len);
    int unsigned     span;
    int unsigned     z;
    logic [ColW-1:0] used;
    logic [ColW-1:0] filled;
    logic [1:0]      scan;
    span = (len > MaxCol) ? MaxCol : len;
    used = (span >= ColW) ? '1 : ((64'd1 << span) - 64'd1);
    used &= surf;
    filled = used;
    scan = ScanOutside;
    for (z = 0; z < span; z++) begin
      case (scan)
        ScanOutside: if (used[z]) scan = ScanBoundOut;
        ScanBoundOut: begin
          if (!used[z]) begin
            // look ahead: nothing left above means this was a lone shell
            if ((used >> z) == '0) begin
              scan = ScanOutside;
            end else begin
              scan = ScanInside;
              filled[z] = 1'b1;
            end
          end
        end
        ScanInside: begin
          if (used[z]) scan = ScanBoundIn;
          else filled[z] = 1'b1;
        end
        default: if (!used[z]) scan = ScanOutside;
      endcase
    end
    return filled;
  endfunction

  // Stack boundary runs with gaps between them, like a voxelized surface.
  function automatic logic [ColW-1:0] shell_column(int unsigned span);
    logic [ColW-1:0] c;
    int unsigned     z;
    int unsigned     k;
    c = '0;
    z = $urandom_range(0, 6);
    while (z < span) begin
      for (k = $urandom_range(1, 3); k > 0 && z < span; k--) begin
        c[z] = 1'b1;
        z++;
      end
      z += $urandom_range(0, 12);
    end
    return c;
  endfunction

  function automatic logic [ColW-1:0] make_column(logic [CfgW-1:0] len);
    int unsigned     span;
    logic [ColW-1:0] noise;
    logic [ColW-1:0] above;
    logic [ColW-1:0] c;
    span = (len > MaxCol) ? MaxCol : len;
    if (span == 0) span = ColW;
    noise = {$urandom, $urandom};
    above = (span >= ColW) ? '0 : ~((64'd1 << span) - 64'd1);
    case ($urandom_range(0, 9))
      0, 1: c = noise;
      2: c = noise & {$urandom, $urandom} & {$urandom, $urandom};
      default: begin
        c = shell_column(span);
        if ($urandom_range(0, 3) == 0) c |= noise & above;
        if ($urandom_range(0, 5) == 0) c ^= 64'd1 << $urandom_range(0, span - 1);
      end
    endcase
    return c;
  endfunction

  task automatic push_column(input logic [ColW-1:0] bits, input bit typed,
                             input logic [ColW-1:0] want);
    in_valid_i    <= 1'b1;
    column_bits_i <= bits;
    do @(posedge clk_i); while (!in_ready_o);
    filled_q = {filled_q, (typed ? want : fill_column(bits, cur_len))};
    sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (filled_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_length(input logic [CfgW-1:0] len);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_len = len;
    len_writes++;
  endtask

  // Receiver: one long hold on request, otherwise a mode that rotates slowly.
  always @(posedge clk_i) begin
    if (long_hold_go && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left      <= HoldLen;
      out_ready_i    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode_e'(cycle_cnt[9:8]))
        RxOpen:   out_ready_i <= 1'b1;
        RxCoin:   out_ready_i <= 1'($urandom_range(0, 1));
        RxSparse: out_ready_i <= ($urandom_range(0, 7) == 0);
        default:  out_ready_i <= (cycle_cnt[2:0] < 3'd5);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filled_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, actual %h",
                 $time, filled_bits_o);
      end else begin
        want_bits = filled_q.pop_front();
        checked++;
        if (filled_bits_o !== want_bits) begin
          errors++;
          $display("%0t: filled_bits mismatch, expected %h, actual %h",
                   $time, want_bits, filled_bits_o);
        end
      end
    end
  end

  initial begin
    logic [CfgW-1:0] phase_len [NumPhases];
    int unsigned     p;
    int unsigned     i;
    int unsigned     n;
    int unsigned     burst_left;
    int unsigned     gap;

    phase_len = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd2, 7'd63, 7'd100, 7'd64,
                  7'd0, 7'd0, 7'd3, 7'd17};
    phase_len[8] = CfgW'($urandom_range(0, 127));
    phase_len[9] = CfgW'($urandom_range(1, 64));
    burst_left = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NumDir; i++) begin
      if (dir_rows[i].len != cur_len) set_length(dir_rows[i].len);
      push_column(dir_rows[i].bits, dir_rows[i].typed, dir_rows[i].want);
    end

    for (p = 0; p < NumPhases; p++) begin
      set_length(phase_len[p]);
      n = (phase_len[p] == 0) ? 40 : 160;
      for (i = 0; i < n; i++) begin
        // long receiver hold while the sender keeps offering items
        if (p == 7 && i == 30) long_hold_go <= 1'b1;
        if (p == 8 && i == 80) wait_drained();
        push_column(make_column(cur_len), 1'b0, '0);
        if (p == 7 && i >= 30 && i < 50) continue;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end else begin
          burst_left--;
        end
      end
    end

    in_valid_i <= 1'b0;
    while (filled_q.size() != 0) @(posedge clk_i);
    repeat (MaxCol + 8) @(posedge clk_i);

    $display("tb: %0d columns sent, %0d results checked", sent, checked);
    $display("tb: %0d column_length writes, zero to 127 and random values", len_writes);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
